[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. They compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a condition in the same cycle as its trigger
`define ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");

// Check a condition in the cycle after its trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, trig, cond)
`define ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

[rtl/core/hkm_pkg.sv]
// ----------------------------------------------------------------------------
// hkm_pkg
// Shared types, codes and the node ordering for the heap k-way merge.
// ----------------------------------------------------------------------------
package hkm_pkg;

    localparam int LIST_COUNT_W = 5;
    localparam logic [LIST_COUNT_W-1:0] LIST_COUNT_RESET = 5'd16;

    // Register index bit of the configuration port
    localparam logic REG_LIST_COUNT = 1'b0;

    typedef struct packed {
        logic signed [31:0] value;
        logic [3:0]         list_id;
        logic               exhausted;
    } hkm_in_t;

    typedef struct packed {
        logic signed [31:0] merged_value;
        logic [3:0]         source_list;
        logic               last;
        logic               no_data;
    } hkm_out_t;

    // One heap entry: value and the list it came from
    typedef struct packed {
        logic signed [31:0] value;
        logic [3:0]         list_id;
    } hkm_node_t;

    localparam int NODE_W = $bits(hkm_node_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_LOAD,
        ST_DOWN,
        ST_EMIT
    } hkm_state_t;

    typedef enum logic [1:0] {
        EMIT_TOP,
        EMIT_END,
        EMIT_NODATA
    } hkm_emit_t;

    // Controller to datapath
    typedef struct packed {
        logic      fill_insert;
        logic      fill_inc;
        logic      fill_clr;
        logic      merge_replace;
        logic      merge_pop;
        logic      load_last;
        logic      up_step;
        logic      dn_step;
        logic      emit;
        hkm_emit_t emit_kind;
    } hkm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic item_ex;
        logic fill_done;
        logic size_zero;
        logic size_one;
        logic size_full;
        logic up_swap;
        logic dn_move;
        logic out_free;
    } hkm_status_t;

    // Order by value, ties to the lower list number
    function automatic logic node_less(input hkm_node_t a, input hkm_node_t b);
        return (a.value < b.value) ||
               ((a.value == b.value) && (a.list_id < b.list_id));
    endfunction

endpackage

[rtl/core/hkm_ram.sv]
// ----------------------------------------------------------------------------
// hkm_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module hkm_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read two
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[rtl/core/hkm_ctrl.sv]
// ----------------------------------------------------------------------------
// hkm_ctrl
// Sequencer for the merge: fill, sift up, load, sift down, emit.
// ----------------------------------------------------------------------------
module hkm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  hkm_pkg::hkm_status_t st,
    output hkm_pkg::hkm_cmd_t    cmd
);

    hkm_pkg::hkm_state_t state_reg, state_next;
    hkm_pkg::hkm_emit_t  kind_reg, kind_next;
    logic                merging_reg, merging_next;
    logic                emit_pend_reg, emit_pend_next;
    logic                do_insert;

    assign do_insert  = !st.item_ex && !st.size_full;
    assign item_stall = (state_reg != hkm_pkg::ST_IDLE);

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hkm_pkg::ST_IDLE;
            kind_reg      <= hkm_pkg::EMIT_TOP;
            merging_reg   <= 1'b0;
            emit_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            merging_reg   <= merging_next;
            emit_pend_reg <= emit_pend_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        merging_next   = merging_reg;
        emit_pend_next = emit_pend_reg;
        case (state_reg)
            hkm_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (!merging_reg)
                    begin
                        if (st.fill_done)
                        begin
                            if (st.size_zero && st.item_ex)
                            begin
                                kind_next  = hkm_pkg::EMIT_NODATA;
                                state_next = hkm_pkg::ST_EMIT;
                            end
                            else
                            begin
                                merging_next   = 1'b1;
                                kind_next      = hkm_pkg::EMIT_TOP;
                                emit_pend_next = 1'b1;
                                state_next     = do_insert ? hkm_pkg::ST_UP
                                                           : hkm_pkg::ST_EMIT;
                            end
                        end
                        else
                        begin
                            emit_pend_next = 1'b0;
                            if (do_insert)
                            begin
                                state_next = hkm_pkg::ST_UP;
                            end
                        end
                    end
                    else if (!st.item_ex)
                    begin
                        kind_next  = hkm_pkg::EMIT_TOP;
                        state_next = hkm_pkg::ST_DOWN;
                    end
                    else if (st.size_one)
                    begin
                        merging_next = 1'b0;
                        kind_next    = hkm_pkg::EMIT_END;
                        state_next   = hkm_pkg::ST_EMIT;
                    end
                    else
                    begin
                        kind_next  = hkm_pkg::EMIT_TOP;
                        state_next = hkm_pkg::ST_LOAD;
                    end
                end
            end
            hkm_pkg::ST_UP:
            begin
                if (!st.up_swap)
                begin
                    state_next = emit_pend_reg ? hkm_pkg::ST_EMIT : hkm_pkg::ST_IDLE;
                end
            end
            hkm_pkg::ST_LOAD:
            begin
                state_next = hkm_pkg::ST_DOWN;
            end
            hkm_pkg::ST_DOWN:
            begin
                if (!st.dn_move)
                begin
                    state_next = hkm_pkg::ST_EMIT;
                end
            end
            hkm_pkg::ST_EMIT:
            begin
                if (st.out_free)
                begin
                    state_next = hkm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hkm_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd           = '0;
        cmd.emit_kind = kind_reg;
        case (state_reg)
            hkm_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (!merging_reg)
                    begin
                        cmd.fill_insert = do_insert;
                        cmd.fill_inc    = !st.fill_done;
                        cmd.fill_clr    = st.fill_done;
                    end
                    else
                    begin
                        cmd.merge_replace = !st.item_ex;
                        cmd.merge_pop     = st.item_ex;
                    end
                end
            end
            hkm_pkg::ST_UP:
            begin
                cmd.up_step = 1'b1;
            end
            hkm_pkg::ST_LOAD:
            begin
                cmd.load_last = 1'b1;
            end
            hkm_pkg::ST_DOWN:
            begin
                cmd.dn_step = 1'b1;
            end
            hkm_pkg::ST_EMIT:
            begin
                cmd.emit = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/core/hkm_dp.sv]
// ----------------------------------------------------------------------------
// hkm_dp
// Heap datapath: node RAM, moving entry, sift compare and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hkm_dp #(
    parameter int MAX_LISTS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hkm_pkg::hkm_in_t                      item,
    input  logic [hkm_pkg::LIST_COUNT_W-1:0]      list_count,
    input  hkm_pkg::hkm_cmd_t                     cmd,
    output hkm_pkg::hkm_status_t                  st,
    output hkm_pkg::hkm_out_t                     result,
    output logic                                  result_valid,
    input  logic                                  result_stall
);

    localparam int AW = $clog2(MAX_LISTS);
    localparam int SW = $clog2(MAX_LISTS + 1);

    logic [SW-1:0]      size_reg;
    logic [SW-1:0]      fill_reg;
    logic [SW-1:0]      eff_count;
    logic [AW-1:0]      pos_reg;
    hkm_pkg::hkm_node_t elem_reg;
    hkm_pkg::hkm_node_t top_reg;
    hkm_pkg::hkm_out_t  out_reg;
    logic               out_valid_reg;

    hkm_pkg::hkm_node_t rd_a, rd_b, wdata, node_in, node_rep, cand, best_node;
    logic               we;
    logic [AW-1:0]      raddr_a, raddr_b;
    logic [AW-1:0]      parent_pos, grand_pos, ins_pos, ins_parent, last_pos, best_pos;
    logic [AW+1:0]      left_idx, right_idx, size_ext;
    logic [AW:0]        nl_idx, nr_idx;
    logic               lv, rv, take_left, take_right, up_swap, dn_move;

    // Clamp the configured count to 1..MAX_LISTS
    always_comb
    begin
        if (list_count == '0)
        begin
            eff_count = SW'(1);
        end
        else if (int'(list_count) > MAX_LISTS)
        begin
            eff_count = SW'(MAX_LISTS);
        end
        else
        begin
            eff_count = SW'(list_count);
        end
    end

    assign node_in  = '{value: item.value, list_id: item.list_id};
    assign node_rep = '{value: item.value, list_id: top_reg.list_id};

    // Tree positions
    assign parent_pos = AW'((pos_reg - 1'b1) >> 1);
    assign grand_pos  = AW'((parent_pos - 1'b1) >> 1);
    assign ins_pos    = size_reg[AW-1:0];
    assign ins_parent = AW'((ins_pos - 1'b1) >> 1);
    assign last_pos   = AW'(size_reg - 1'b1);
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + 1'b1;
    assign size_ext   = (AW + 2)'(size_reg);
    assign lv         = left_idx < size_ext;
    assign rv         = right_idx < size_ext;

    // Compare the moving entry against parent or children
    assign up_swap    = (pos_reg != '0) && hkm_pkg::node_less(elem_reg, rd_a);
    assign take_left  = lv && hkm_pkg::node_less(rd_a, elem_reg);
    assign cand       = take_left ? rd_a : elem_reg;
    assign take_right = rv && hkm_pkg::node_less(rd_b, cand);
    assign dn_move    = take_left || take_right;
    assign best_node  = take_right ? rd_b : rd_a;
    assign best_pos   = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
    assign nl_idx     = {best_pos, 1'b1};
    assign nr_idx     = nl_idx + 1'b1;

    // Select read addresses
    always_comb
    begin
        raddr_a = parent_pos;
        raddr_b = '0;
        if (cmd.fill_insert)
        begin
            raddr_a = ins_parent;
        end
        else if (cmd.merge_replace || cmd.load_last)
        begin
            raddr_a = AW'(1);
            raddr_b = AW'(2);
        end
        else if (cmd.merge_pop)
        begin
            raddr_a = last_pos;
        end
        else if (cmd.up_step)
        begin
            raddr_a = grand_pos;
        end
        else if (cmd.dn_step)
        begin
            raddr_a = nl_idx[AW-1:0];
            raddr_b = nr_idx[AW-1:0];
        end
    end

    // Write back at the current position
    always_comb
    begin
        we    = 1'b0;
        wdata = elem_reg;
        if (cmd.up_step)
        begin
            we    = 1'b1;
            wdata = up_swap ? rd_a : elem_reg;
        end
        else if (cmd.dn_step)
        begin
            we    = 1'b1;
            wdata = dn_move ? best_node : elem_reg;
        end
    end

    hkm_ram #(
        .WIDTH (hkm_pkg::NODE_W),
        .DEPTH (MAX_LISTS)
    ) u_heap (
        .clk     (clk),
        .we      (we),
        .waddr   (pos_reg),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rd_a),
        .raddr_b (raddr_b),
        .rdata_b (rd_b)
    );

    // Track heap size, fill count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.fill_insert)
            begin
                size_reg <= size_reg + 1'b1;
            end
            else if (cmd.merge_pop)
            begin
                size_reg <= size_reg - 1'b1;
            end
            if (cmd.fill_clr)
            begin
                fill_reg <= '0;
            end
            else if (cmd.fill_inc)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Advance the moving entry, mirror the root, load the result word
    always_ff @(posedge clk)
    begin
        if (cmd.fill_insert)
        begin
            pos_reg  <= ins_pos;
            elem_reg <= node_in;
        end
        else if (cmd.merge_replace)
        begin
            pos_reg  <= '0;
            elem_reg <= node_rep;
        end
        else if (cmd.load_last)
        begin
            pos_reg  <= '0;
            elem_reg <= rd_a;
        end
        else if (cmd.up_step && up_swap)
        begin
            pos_reg <= parent_pos;
        end
        else if (cmd.dn_step && dn_move)
        begin
            pos_reg <= best_pos;
        end
        if (we && (pos_reg == '0))
        begin
            top_reg <= wdata;
        end
        if (cmd.emit)
        begin
            case (cmd.emit_kind)
                hkm_pkg::EMIT_TOP:
                begin
                    out_reg <= '{merged_value: top_reg.value, source_list: top_reg.list_id,
                                 last: 1'b0, no_data: 1'b0};
                end
                hkm_pkg::EMIT_NODATA:
                begin
                    out_reg <= '{merged_value: '0, source_list: '0,
                                 last: 1'b1, no_data: 1'b1};
                end
                default:
                begin
                    out_reg <= '{merged_value: '0, source_list: '0,
                                 last: 1'b1, no_data: 1'b0};
                end
            endcase
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    // Status back to the sequencer
    always_comb
    begin
        st.item_ex   = item.exhausted;
        st.fill_done = ({1'b0, fill_reg} + 1'b1) >= {1'b0, eff_count};
        st.size_zero = (size_reg == '0);
        st.size_one  = (size_reg == SW'(1));
        st.size_full = (size_reg == SW'(MAX_LISTS));
        st.up_swap   = up_swap;
        st.dn_move   = dn_move;
        st.out_free  = !out_valid_reg || !result_stall;
    end

    `ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid_reg)
    `ASSERT_NEXT(a_insert_grows, clk, rst_n, cmd.fill_insert, size_reg == $past(size_reg) + 1'b1)
    `ASSERT_NEXT(a_sift_deeper, clk, rst_n, cmd.dn_step && dn_move, pos_reg > $past(pos_reg))
    `ASSERT_SAME(a_size_bound, clk, rst_n, cmd.fill_insert, size_reg < SW'(MAX_LISTS))

endmodule

[rtl/core/heap_k_way_merge.sv]
// ----------------------------------------------------------------------------
// heap_k_way_merge
// K-way merge of sorted signed streams through a min-heap of (value, list).
// ----------------------------------------------------------------------------
// Use: program list_count over the APB port while idle, then send one head
// word per list on the item channel (value, list_id, exhausted). After the
// last head word a result word gives the minimum and its source_list; the
// next item word must come from that list (its list_id is then ignored).
// Each merge item yields one result word; when the heap drains, a word with
// last=1 (and no_data=1 if every list was empty) closes the run and the block
// returns to the fill phase.
// Timing: the item channel takes one word, then stalls while the heap is
// updated; the next word is taken in the cycle the block is back in idle.
// A fill word is taken in idle; an inserted head adds one sift-up step per
// level climbed plus one to settle, and the final head word adds a step to
// load the result register. A merge word is taken in idle, then a step
// fetches the last entry when its list is exhausted, one sift-down step per
// level moved plus one to settle follows, and a last step loads the result
// register; when an exhausted mark drains the heap, only the step that
// loads the result register follows.
// The rate is set by the heap RAM, one compare-and-write level per cycle.
// A stalled result holds in the output register; a new item is still taken
// meanwhile and waits in the emit step until the register frees up.
// Reset empties the heap, enters the fill phase and sets list_count to 16;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module heap_k_way_merge #(
    parameter int MAX_LISTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  hkm_pkg::hkm_in_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output hkm_pkg::hkm_out_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [hkm_pkg::LIST_COUNT_W-1:0] list_count_reg;
    hkm_pkg::hkm_cmd_t                cmd;
    hkm_pkg::hkm_status_t             st;
    logic                             reg_sel;

    assign reg_sel = (paddr[2] == hkm_pkg::REG_LIST_COUNT);
    assign pready  = 1'b1;

    // Write the list count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_count_reg <= hkm_pkg::LIST_COUNT_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            list_count_reg <= pwdata[hkm_pkg::LIST_COUNT_W-1:0];
        end
    end

    // Read back
    assign prdata = reg_sel ? {{(32 - hkm_pkg::LIST_COUNT_W){1'b0}}, list_count_reg} : '0;

    hkm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .st         (st),
        .cmd        (cmd)
    );

    hkm_dp #(
        .MAX_LISTS (MAX_LISTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .list_count   (list_count_reg),
        .cmd          (cmd),
        .st           (st),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule
